>>> src/utf8_stream_validator_core_assert.svh
// ============================================================================
// utf8_stream_validator_core_assert.svh
// Assertion macros shared by the UTF-8 stream validator RTL.
// ============================================================================
`ifndef UTF8_STREAM_VALIDATOR_CORE_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define USV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define USV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/usv_pkg.sv
// ============================================================================
// usv_pkg
// Shared widths, types and byte classing for the UTF-8 stream validator.
// ============================================================================
`default_nettype none

package usv_pkg;

  // Width of one string byte and of the pending continuation counter.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PEND_W = 2;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [PEND_W-1:0] pend_t;

  // Result of classing one byte that arrives with nothing pending.
  typedef struct packed {
    logic  bad;   // Stray continuation or 11111xxx lead.
    pend_t need;  // Continuation bytes that the lead announces.
  } lead_class_t;

  // True for a 10xxxxxx continuation byte.
  function automatic logic is_cont(input byte_t b);
    return b[7:6] == 2'b10;
  endfunction

  // Class a lead byte by its top bits.
  function automatic lead_class_t class_lead(input byte_t b);
    lead_class_t c;
    c.bad  = 1'b0;
    c.need = pend_t'(0);
    priority casez (b[7:3])
      5'b0????: c.need = pend_t'(0);
      5'b110??: c.need = pend_t'(1);
      5'b1110?: c.need = pend_t'(2);
      5'b11110: c.need = pend_t'(3);
      default:  c.bad  = 1'b1;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> src/usv_ifs.sv
// ============================================================================
// usv_ifs
// Valid/ready channel interfaces for string bytes and per-string results.
// ============================================================================
`default_nettype none

// One string byte per item, with a flag on the final byte.
interface usv_in_if;
  logic               valid;
  logic               ready;
  usv_pkg::byte_t     data_byte;
  logic               last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// One validity verdict per string.
interface usv_out_if;
  logic valid;
  logic ready;
  logic string_valid;

  modport source (output valid, output string_valid, input ready);
  modport sink   (input valid, input string_valid, output ready);
endinterface

`default_nettype wire

>>> src/utf8_stream_validator_core.sv
// ============================================================================
// utf8_stream_validator_core
// Checks a byte stream for well formed UTF-8 and reports once per string.
// ============================================================================
//
//  Channel   Dir  Payload                    Item
//  in_chan   in   data_byte[7:0], last_byte  one byte of the string
//  out_chan  out  string_valid               verdict on the final byte
//
//  A new byte is accepted every cycle unless a stalled result blocks input.
//  The verdict appears in the result register the cycle after the final
//  byte is accepted, and the per-string state is cleared on that edge.
//  A stalled result blocks input only when the result register is full
//  and out_chan.ready is low.
//  Reset is synchronous, active low, and clears the state and the result valid flag.
//
`default_nettype none

`include "utf8_stream_validator_core_assert.svh"

module utf8_stream_validator_core (
  input  wire logic clk,
  input  wire logic rst_n,
  usv_in_if.sink    in_chan,
  usv_out_if.source out_chan
);
  import usv_pkg::*;

  pend_t       pend_r, pend_nxt;
  logic        err_r, err_nxt;
  logic        out_valid_r;
  logic        string_valid_r, string_valid_nxt;
  logic        in_acc;
  logic        out_acc;
  lead_class_t lead;

  // Accept a byte whenever the result register is free or being drained.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_acc       = out_valid_r && out_chan.ready;

  assign lead = class_lead(in_chan.data_byte);

  // Next state for one byte, then the verdict when it ends the string.
  always_comb begin
    pend_nxt = pend_r;
    err_nxt  = err_r;
    if (pend_r != pend_t'(0)) begin
      if (is_cont(in_chan.data_byte)) begin
        pend_nxt = pend_r - pend_t'(1);
      end else begin
        err_nxt  = 1'b1;
        pend_nxt = pend_t'(0);
      end
    end else begin
      pend_nxt = lead.need;
      if (lead.bad) begin
        err_nxt = 1'b1;
      end
    end
    string_valid_nxt = !err_nxt && (pend_nxt == pend_t'(0));
  end

  // String state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= pend_t'(0);
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        if (in_chan.last_byte) begin
          pend_r <= pend_t'(0);
          err_r  <= 1'b0;
        end else begin
          pend_r <= pend_nxt;
          err_r  <= err_nxt;
        end
      end
      if (in_acc && in_chan.last_byte) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Verdict payload is loaded with the final byte and needs no reset.
  always_ff @(posedge clk) begin
    if (in_acc && in_chan.last_byte) begin
      string_valid_r <= string_valid_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.string_valid = string_valid_r;

  // A new verdict only follows an accepted final byte.
  `USV_ASSERT_IMP(a_result_from_last, clk, rst_n, $rose(out_valid_r),
    $past(in_acc && in_chan.last_byte), "result raised without a final byte")

  // The final byte leaves the string state cleared.
  `USV_ASSERT_NEXT(a_clear_on_last, clk, rst_n, in_acc && in_chan.last_byte,
    pend_r == pend_t'(0) && !err_r, "state not cleared after final byte")

  // A string already in error is always reported invalid.
  `USV_ASSERT_NEXT(a_error_sticky, clk, rst_n, in_acc && in_chan.last_byte && err_r,
    out_valid_r && !string_valid_r, "erroneous string reported valid")

endmodule

`default_nettype wire
